// ----- sv/rtp_pkg.sv -----
`timescale 1ns / 1ps

package rtp_pkg;

  // Parse phase within one colour component.
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Largest value a component may take.
  localparam logic [11:0] MAX_COMPONENT = 12'd255;

  // Index of the last (blue) component.
  localparam logic [1:0] LAST_INDEX = 2'd2;

  // Outcome of folding one decimal digit into the running value.
  typedef struct packed {
    logic [7:0] value;
    logic       overflow;
  } acc_res_t;

  // Space, tab, newline, vertical tab, form feed or carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ----- sv/rtp_in_if.sv -----
`timescale 1ns / 1ps

// Character channel: one byte of text per item.
interface rtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       already_set;

  modport source (output valid, output ch, output already_set, input ready);
  modport sink   (input valid, input ch, input already_set, output ready);
endinterface

// ----- sv/rtp_out_if.sv -----
`timescale 1ns / 1ps

// Result channel: status and packed colour per item.
interface rtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [23:0] color;

  modport source (output valid, output status, output color, input ready);
  modport sink   (input valid, input status, input color, output ready);
endinterface

// ----- sv/rtp_digit_acc.sv -----
`timescale 1ns / 1ps

module rtp_digit_acc (
  input  logic [7:0]       acc,
  input  logic [7:0]       ch,
  output rtp_pkg::acc_res_t res
);
  import rtp_pkg::*;

  logic [3:0]  digit;
  logic [11:0] times_ten;
  logic [11:0] sum;

  // Multiply by ten as two shifts and an add, then add the new digit.
  always_comb begin
    digit     = 4'(ch - CHAR_ZERO);
    times_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    sum       = times_ten + {8'd0, digit};
    res.value    = sum[7:0];
    res.overflow = (sum > MAX_COMPONENT);
  end

endmodule

// ----- sv/rgb_triplet_text_parser_unit.sv -----
`timescale 1ns / 1ps

// Comma separated decimal RGB text parser.
// The chars channel takes one byte of text per item together with the
// already_set flag; a zero byte ends the string. Every other byte updates
// the parse state and gives no result. The terminator gives exactly one item
// on the results channel: status (ok, duplicate, malformed) and the packed
// colour red<<16 | green<<8 | blue, which is zero unless the status is ok.
// Throughput is one byte per cycle unless a terminator waits on a pending
// result: the parse state is updated in the cycle the byte is accepted, by
// a shallow classify and multiply-by-ten step. results.valid rises in the
// cycle after the terminator is accepted, set by the result register.
// After reset, and after every terminator, the parser expects the leading
// whitespace of the red component with no error latched.
// If the receiver stalls, the result is held in its register and further
// bytes are still accepted as long as none of them is a terminator; a
// terminator waits on chars.ready until the pending result has been taken.
module rgb_triplet_text_parser_unit (
  input logic      clk,
  input logic      rst,
  rtp_in_if.sink   chars,
  rtp_out_if.source results
);
  import rtp_pkg::*;

  // Parse state.
  logic [1:0]  component_index, component_index_next;
  phase_t      component_phase, component_phase_next;
  logic [7:0]  accumulator, accumulator_next;
  logic [23:0] packed_value, packed_value_next;
  logic        error_seen, error_seen_next;

  // Result register.
  logic        res_valid, res_valid_next;
  logic [1:0]  res_status, res_status_next;
  logic [23:0] res_color, res_color_next;

  logic     accept;
  logic     is_term;
  logic     phase_done;
  acc_res_t digit_res;

  rtp_digit_acc u_digit_acc (
    .acc (accumulator),
    .ch  (chars.ch),
    .res (digit_res)
  );

  // A terminator may only enter once the result register is free.
  assign is_term     = (chars.ch == CHAR_NUL);
  assign chars.ready = !(is_term && res_valid && !results.ready);
  assign accept      = chars.valid && chars.ready;

  assign results.valid  = res_valid;
  assign results.status = res_status;
  assign results.color  = res_color;

  // Next parse state.
  always_comb begin
    component_index_next = component_index;
    component_phase_next = component_phase;
    accumulator_next     = accumulator;
    packed_value_next    = packed_value;
    error_seen_next      = error_seen;
    if (accept) begin
      if (is_term) begin
        component_index_next = 2'd0;
        component_phase_next = PH_LEAD;
        accumulator_next     = 8'd0;
        packed_value_next    = 24'd0;
        error_seen_next      = 1'b0;
      end else if (!error_seen) begin
        case (component_phase)
          PH_LEAD: begin
            if (is_digit(chars.ch)) begin
              accumulator_next     = 8'(chars.ch - CHAR_ZERO);
              component_phase_next = PH_DIGIT;
            end else if (!is_ws(chars.ch)) begin
              error_seen_next = 1'b1;
            end
          end
          PH_DIGIT, PH_TRAIL: begin
            if (is_digit(chars.ch) && (component_phase == PH_DIGIT)) begin
              if (digit_res.overflow) begin
                error_seen_next = 1'b1;
              end else begin
                accumulator_next = digit_res.value;
              end
            end else if (is_ws(chars.ch)) begin
              component_phase_next = PH_TRAIL;
            end else if (chars.ch == CHAR_COMMA) begin
              // Commit this component and move on; a fourth is an error.
              if (component_index < LAST_INDEX) begin
                packed_value_next    = {packed_value[15:0], accumulator};
                component_index_next = component_index + 2'd1;
                component_phase_next = PH_LEAD;
                accumulator_next     = 8'd0;
              end else begin
                error_seen_next = 1'b1;
              end
            end else begin
              error_seen_next = 1'b1;
            end
          end
          default: begin
            error_seen_next = 1'b1;
          end
        endcase
      end
    end
  end

  // Next result register contents.
  always_comb begin
    phase_done      = (component_phase == PH_DIGIT) || (component_phase == PH_TRAIL);
    res_valid_next  = res_valid && !results.ready;
    res_status_next = res_status;
    res_color_next  = res_color;
    if (accept && is_term) begin
      res_valid_next = 1'b1;
      res_color_next = 24'd0;
      if (chars.already_set) begin
        res_status_next = ST_DUP;
      end else if (error_seen || (component_index != LAST_INDEX) || !phase_done) begin
        res_status_next = ST_BAD;
      end else begin
        res_status_next = ST_OK;
        res_color_next  = {packed_value[15:0], accumulator};
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      component_index <= 2'd0;
      component_phase <= PH_LEAD;
      accumulator     <= 8'd0;
      packed_value    <= 24'd0;
      error_seen      <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      component_index <= component_index_next;
      component_phase <= component_phase_next;
      accumulator     <= accumulator_next;
      packed_value    <= packed_value_next;
      error_seen      <= error_seen_next;
      res_valid       <= res_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_color  <= res_color_next;
  end

  // A terminator always leaves the parser in its starting state.
  a_term_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && is_term) |=> (component_index == 2'd0 && component_phase == PH_LEAD &&
                             !error_seen && packed_value == 24'd0))
    else $error("parser state not cleared after terminator");

  // A new result only appears after a terminator was accepted.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(accept && is_term))
    else $error("result raised without a terminator");

  // A latched error persists until the terminator.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_seen && !(accept && is_term)) |=> error_seen)
    else $error("error flag dropped before terminator");

  // The component index never passes the last component.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    component_index != 2'd3)
    else $error("component index out of range");

  // A latched error with the duplicate flag clear is reported as malformed text.
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (accept && is_term && !chars.already_set && error_seen) |=> (res_status == ST_BAD))
    else $error("latched error not reported");

endmodule
